FILE: rtl/cfre_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cell formula range evaluator package
// Shared widths, codes and the command and status records between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package cfre_pkg;

    localparam int CELL_COUNT = 1024;
    localparam int CELL_AW    = $clog2(CELL_COUNT);
    localparam int VAL_W      = 32;
    localparam int CELL_W     = 11;
    localparam int COLS_W     = 11;
    localparam int KIND_W     = 3;
    localparam int OP_W       = 3;
    localparam int STAT_W     = 2;
    localparam int TGT_W      = 10;
    localparam int N_W        = 11;
    localparam int SUM_W      = 43;
    localparam int ACC_W      = 74;
    localparam int DIV_DW     = 74;
    localparam int DIV_VW     = 32;
    localparam int DIV_CW     = 7;
    localparam int SQ_IW      = 64;
    localparam int SQ_OW      = 32;
    localparam int SQ_CW      = 6;
    localparam int MID_W      = 43;
    localparam int SHORT_W    = 11;
    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;

    localparam logic [COLS_W-1:0] COLS_RESET = 11'd32;

    localparam logic [DIV_CW-1:0] DIV_LEN_SHORT = DIV_CW'(SHORT_W);
    localparam logic [DIV_CW-1:0] DIV_LEN_MID   = DIV_CW'(MID_W);
    localparam logic [DIV_CW-1:0] DIV_LEN_LONG  = DIV_CW'(DIV_DW);

    localparam logic [KIND_W-1:0] KIND_CONST = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ARITH = 3'd1;
    localparam logic [KIND_W-1:0] KIND_MIN   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_MAX   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_AVG   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_SUM   = 3'd5;
    localparam logic [KIND_W-1:0] KIND_STDEV = 3'd6;

    localparam logic [OP_W-1:0] OP_ADD = 3'd0;
    localparam logic [OP_W-1:0] OP_SUB = 3'd1;
    localparam logic [OP_W-1:0] OP_MUL = 3'd2;
    localparam logic [OP_W-1:0] OP_DIV = 3'd3;

    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_UNSUPP   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_DIV_ZERO = 2'd2;
    localparam logic [STAT_W-1:0] STAT_INVERTED = 2'd3;

    localparam logic [APB_AW-1:0] REG_COLS = 3'd0;

    typedef enum logic [2:0] {
        DS_FIRST,
        DS_SECOND,
        DS_ARITH,
        DS_MEAN,
        DS_VAR
    } t_div_sel;

    typedef enum logic [1:0] {
        RS_A,
        RS_B,
        RS_WALK
    } t_rd_sel;

    typedef enum logic [2:0] {
        RES_CONST,
        RES_ALU,
        RES_MIN,
        RES_MAX,
        RES_SUM,
        RES_ROOT
    } t_res_src;

    typedef struct packed {
        logic              load;
        logic              clr_step;
        logic              rd_en;
        t_rd_sel           rd_sel;
        logic              lat_a;
        logic              lat_b;
        logic              walk_init;
        logic              walk_step;
        logic              pass2;
        logic              div_start;
        t_div_sel          div_sel;
        logic              div_take;
        logic              sqrt_start;
        logic              res_load;
        t_res_src          res_src;
        logic              err_load;
        logic [STAT_W-1:0] err_code;
        logic              finish;
    } t_cmd;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [OP_W-1:0]   op;
        logic              neg1;
        logic              neg2;
        logic              b_zero;
        logic              inverted;
        logic              walk_last;
        logic              pipe_busy;
        logic              div_busy;
        logic              sqrt_busy;
        logic              clr_last;
        logic              out_free;
    } t_sts;

endpackage

FILE: rtl/cfre_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module cfre_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/cfre_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Iterative unsigned divider
// Restoring division, one quotient bit per cycle; the dividend arrives left
// aligned and the caller gives the number of bits to process.
// ----------------------------------------------------------------------------
module cfre_div
    import cfre_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIV_DW-1:0] i_dividend,
    input  logic [DIV_VW-1:0] i_divisor,
    input  logic [DIV_CW-1:0] i_len,
    output logic              o_busy,
    output logic [DIV_DW-1:0] o_quot,
    output logic [DIV_VW-1:0] o_rem
);

    logic [DIV_DW-1:0] r_q;
    logic [DIV_VW-1:0] r_rem;
    logic [DIV_VW-1:0] r_dvs;
    logic [DIV_CW-1:0] r_cnt;
    logic [DIV_VW:0]   w_rem_sh;
    logic [DIV_VW:0]   w_diff;
    logic              w_ge;

    assign w_rem_sh = {r_rem, r_q[DIV_DW-1]};
    assign w_diff   = w_rem_sh - {1'b0, r_dvs};
    assign w_ge     = w_rem_sh >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= i_len;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - DIV_CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_cnt != '0) begin
            r_q   <= {r_q[DIV_DW-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DIV_VW-1:0] : w_rem_sh[DIV_VW-1:0];
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quot = r_q;
    assign o_rem  = r_rem;

endmodule

FILE: rtl/cfre_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Iterative integer square root
// Digit-by-digit floor square root of a 64-bit value, one root bit a cycle.
// ----------------------------------------------------------------------------
module cfre_sqrt
    import cfre_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [SQ_IW-1:0] i_x,
    output logic             o_busy,
    output logic [SQ_OW-1:0] o_root
);

    logic [SQ_IW-1:0] r_x;
    logic [SQ_OW+2:0] r_rem;
    logic [SQ_OW-1:0] r_root;
    logic [SQ_CW:0]   r_cnt;
    logic [SQ_OW+2:0] w_rem_sh;
    logic [SQ_OW+2:0] w_trial;
    logic             w_ge;

    assign w_rem_sh = {r_rem[SQ_OW:0], r_x[SQ_IW-1 -: 2]};
    assign w_trial  = {1'b0, r_root, 2'b01};
    assign w_ge     = w_rem_sh >= w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= (SQ_CW+1)'(SQ_OW);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - (SQ_CW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= i_x;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_cnt != '0) begin
            r_x    <= {r_x[SQ_IW-3:0], 2'b00};
            r_rem  <= w_ge ? (w_rem_sh - w_trial) : w_rem_sh;
            r_root <= {r_root[SQ_OW-2:0], w_ge};
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_root = r_root;

endmodule

FILE: rtl/cfre_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cell formula range evaluator controller
// Sequences operand reads, range walks, divisions and the square root for
// one formula at a time.
// ----------------------------------------------------------------------------
module cfre_ctrl
    import cfre_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_in_ready
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_RD_B,
        S_LAT_B,
        S_EXEC,
        S_DIV_WAIT,
        S_RNG_CHECK,
        S_WALK,
        S_DRAIN,
        S_SQRT,
        S_SQRT_WAIT,
        S_FINISH
    } t_state;

    t_state   r_state, n_state;
    t_div_sel r_div_sel, n_div_sel;
    logic     r_pass2, n_pass2;
    t_cmd     w_cmd;

    always_comb begin
        n_state        = r_state;
        n_div_sel      = r_div_sel;
        n_pass2        = r_pass2;
        w_cmd          = '0;
        w_cmd.pass2    = r_pass2;
        w_cmd.div_sel  = r_div_sel;
        w_cmd.rd_sel   = RS_A;
        w_cmd.res_src  = RES_CONST;
        w_cmd.err_code = STAT_OK;
        case (r_state)
            S_CLEAR: begin
                w_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.load = 1'b1;
                    n_pass2    = 1'b0;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_sts.kind)
                    KIND_CONST: begin
                        w_cmd.res_load = 1'b1;
                        w_cmd.res_src  = RES_CONST;
                        n_state        = S_FINISH;
                    end
                    KIND_ARITH: begin
                        if (i_sts.op > OP_DIV) begin
                            w_cmd.err_load = 1'b1;
                            w_cmd.err_code = STAT_UNSUPP;
                            n_state        = S_FINISH;
                        end else begin
                            w_cmd.rd_en  = 1'b1;
                            w_cmd.rd_sel = RS_A;
                            n_state      = S_RD_B;
                        end
                    end
                    KIND_MIN, KIND_MAX, KIND_AVG, KIND_SUM, KIND_STDEV: begin
                        if (i_sts.neg1 || i_sts.neg2) begin
                            w_cmd.err_load = 1'b1;
                            w_cmd.err_code = STAT_INVERTED;
                            n_state        = S_FINISH;
                        end else begin
                            // split the top-left corner into row and column
                            w_cmd.div_start = 1'b1;
                            w_cmd.div_sel   = DS_FIRST;
                            n_div_sel       = DS_FIRST;
                            n_state         = S_DIV_WAIT;
                        end
                    end
                    default: begin
                        w_cmd.err_load = 1'b1;
                        w_cmd.err_code = STAT_UNSUPP;
                        n_state        = S_FINISH;
                    end
                endcase
            end
            S_RD_B: begin
                w_cmd.lat_a  = 1'b1;
                w_cmd.rd_en  = 1'b1;
                w_cmd.rd_sel = RS_B;
                n_state      = S_LAT_B;
            end
            S_LAT_B: begin
                w_cmd.lat_b = 1'b1;
                n_state     = S_EXEC;
            end
            S_EXEC: begin
                if (i_sts.op == OP_DIV) begin
                    if (i_sts.b_zero) begin
                        w_cmd.err_load = 1'b1;
                        w_cmd.err_code = STAT_DIV_ZERO;
                        n_state        = S_FINISH;
                    end else begin
                        w_cmd.div_start = 1'b1;
                        w_cmd.div_sel   = DS_ARITH;
                        n_div_sel       = DS_ARITH;
                        n_state         = S_DIV_WAIT;
                    end
                end else begin
                    w_cmd.res_load = 1'b1;
                    w_cmd.res_src  = RES_ALU;
                    n_state        = S_FINISH;
                end
            end
            S_DIV_WAIT: begin
                if (!i_sts.div_busy) begin
                    w_cmd.div_take = 1'b1;
                    case (r_div_sel)
                        DS_FIRST: begin
                            w_cmd.div_start = 1'b1;
                            w_cmd.div_sel   = DS_SECOND;
                            n_div_sel       = DS_SECOND;
                        end
                        DS_SECOND: begin
                            n_state = S_RNG_CHECK;
                        end
                        DS_MEAN: begin
                            if (i_sts.kind == KIND_AVG) begin
                                n_state = S_FINISH;
                            end else begin
                                // second pass over the rectangle for deviations
                                w_cmd.walk_init = 1'b1;
                                w_cmd.pass2     = 1'b1;
                                n_pass2         = 1'b1;
                                n_state         = S_WALK;
                            end
                        end
                        DS_VAR: begin
                            n_state = S_SQRT;
                        end
                        default: begin
                            n_state = S_FINISH;
                        end
                    endcase
                end
            end
            S_RNG_CHECK: begin
                if (i_sts.inverted) begin
                    w_cmd.err_load = 1'b1;
                    w_cmd.err_code = STAT_INVERTED;
                    n_state        = S_FINISH;
                end else begin
                    w_cmd.walk_init = 1'b1;
                    n_state         = S_WALK;
                end
            end
            S_WALK: begin
                w_cmd.rd_en     = 1'b1;
                w_cmd.rd_sel    = RS_WALK;
                w_cmd.walk_step = 1'b1;
                if (i_sts.walk_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_sts.pipe_busy) begin
                    if (r_pass2) begin
                        w_cmd.div_start = 1'b1;
                        w_cmd.div_sel   = DS_VAR;
                        n_div_sel       = DS_VAR;
                        n_state         = S_DIV_WAIT;
                    end else begin
                        case (i_sts.kind)
                            KIND_MIN: begin
                                w_cmd.res_load = 1'b1;
                                w_cmd.res_src  = RES_MIN;
                                n_state        = S_FINISH;
                            end
                            KIND_MAX: begin
                                w_cmd.res_load = 1'b1;
                                w_cmd.res_src  = RES_MAX;
                                n_state        = S_FINISH;
                            end
                            KIND_SUM: begin
                                w_cmd.res_load = 1'b1;
                                w_cmd.res_src  = RES_SUM;
                                n_state        = S_FINISH;
                            end
                            default: begin
                                w_cmd.div_start = 1'b1;
                                w_cmd.div_sel   = DS_MEAN;
                                n_div_sel       = DS_MEAN;
                                n_state         = S_DIV_WAIT;
                            end
                        endcase
                    end
                end
            end
            S_SQRT: begin
                w_cmd.sqrt_start = 1'b1;
                n_state          = S_SQRT_WAIT;
            end
            S_SQRT_WAIT: begin
                if (!i_sts.sqrt_busy) begin
                    w_cmd.res_load = 1'b1;
                    w_cmd.res_src  = RES_ROOT;
                    n_state        = S_FINISH;
                end
            end
            S_FINISH: begin
                // hold until the output register can take the transfer
                if (i_sts.out_free) begin
                    w_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_div_sel <= DS_FIRST;
            r_pass2   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_div_sel <= n_div_sel;
            r_pass2   <= n_pass2;
        end
    end

    assign o_cmd      = w_cmd;
    assign o_in_ready = (r_state == S_IDLE);

endmodule

FILE: rtl/cfre_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cell formula range evaluator datapath
// Cell store, operand registers, range walker, accumulators, divider, square
// root and the output register.
// ----------------------------------------------------------------------------
module cfre_datapath
    import cfre_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    input  logic [COLS_W-1:0] i_cols,
    input  logic [KIND_W-1:0] i_formula_kind,
    input  logic [OP_W-1:0]   i_arith_op,
    input  logic [CELL_W-1:0] i_first_cell,
    input  logic [CELL_W-1:0] i_second_cell,
    input  logic [VAL_W-1:0]  i_constant_value,
    input  logic [TGT_W-1:0]  i_target_cell,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [VAL_W-1:0]  o_result_value,
    output logic [STAT_W-1:0] o_status
);

    // captured item
    logic [KIND_W-1:0] r_kind;
    logic [OP_W-1:0]   r_op;
    logic [CELL_W-1:0] r_c1, r_c2;
    logic [VAL_W-1:0]  r_k;
    logic [TGT_W-1:0]  r_tgt;

    logic [VAL_W-1:0]  r_a, r_b;
    logic [COLS_W-1:0] r_fr, r_fc, r_tr, r_tc;
    logic [CELL_AW-1:0] r_addr, r_row;
    logic [COLS_W-1:0] r_ci, r_ri;

    logic                    r_v1, r_v2, r_v3;
    logic [N_W-1:0]          r_n;
    logic signed [SUM_W-1:0] r_sum;
    logic signed [VAL_W-1:0] r_mn, r_mx;
    logic [VAL_W-1:0]        r_mean;
    logic [VAL_W-1:0]        r_d;
    logic [2*VAL_W-1:0]      r_sq;
    logic [ACC_W-1:0]        r_acc;
    logic [SQ_IW-1:0]        r_var;
    t_div_sel                r_dsel;

    logic [VAL_W-1:0]  r_res;
    logic [STAT_W-1:0] r_stat;
    logic              r_out_valid;
    logic [VAL_W-1:0]  r_out_val;
    logic [STAT_W-1:0] r_out_stat;
    logic [CELL_AW-1:0] r_clr_addr;

    logic [COLS_W-1:0]  w_cols;
    logic [COLS_W-1:0]  w_wlen, w_hlen;
    logic [VAL_W-1:0]   w_ram_q;
    logic signed [VAL_W-1:0] w_v;
    logic signed [VAL_W:0]   w_dev;
    logic [VAL_W-1:0]   w_dmag;
    logic               w_ram_we, w_ram_re;
    logic [CELL_AW-1:0] w_waddr, w_raddr;
    logic [VAL_W-1:0]   w_wdata;
    logic [DIV_DW-1:0]  w_dvd;
    logic [DIV_VW-1:0]  w_dvs;
    logic [DIV_CW-1:0]  w_dlen;
    logic [DIV_DW-1:0]  w_quot;
    logic [DIV_VW-1:0]  w_rem;
    logic               w_div_busy;
    logic [SQ_OW-1:0]   w_root;
    logic               w_sqrt_busy;
    logic [VAL_W-1:0]   w_a_mag, w_b_mag;
    logic [SUM_W-1:0]   w_sum_mag;
    logic [VAL_W-1:0]   w_q32, w_qfix;
    logic               w_qneg;
    logic [VAL_W-1:0]   w_alu;
    logic [VAL_W-1:0]   w_res_sel;

    // a column count of zero acts as one
    assign w_cols = (i_cols == '0) ? COLS_W'(1) : i_cols;
    assign w_wlen = r_tc - r_fc;
    assign w_hlen = r_tr - r_fr;

    assign w_v    = $signed(w_ram_q);
    assign w_dev  = {w_v[VAL_W-1], w_v} - {r_mean[VAL_W-1], r_mean};
    assign w_dmag = w_dev[VAL_W] ? VAL_W'(-w_dev) : w_dev[VAL_W-1:0];

    assign w_a_mag   = r_a[VAL_W-1] ? (VAL_W'(0) - r_a) : r_a;
    assign w_b_mag   = r_b[VAL_W-1] ? (VAL_W'(0) - r_b) : r_b;
    assign w_sum_mag = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);

    // cell store
    assign w_ram_we = i_cmd.clr_step || (i_cmd.finish && (r_stat == STAT_OK));
    assign w_waddr  = i_cmd.clr_step ? r_clr_addr : CELL_AW'(r_tgt);
    assign w_wdata  = i_cmd.clr_step ? '0 : r_res;
    assign w_ram_re = i_cmd.rd_en;

    always_comb begin
        case (i_cmd.rd_sel)
            RS_A:    w_raddr = r_c1[CELL_AW-1:0];
            RS_B:    w_raddr = r_c2[CELL_AW-1:0];
            RS_WALK: w_raddr = r_addr;
            default: w_raddr = r_addr;
        endcase
    end

    cfre_ram #(
        .WIDTH (VAL_W),
        .DEPTH (CELL_COUNT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_raddr),
        .o_rdata (w_ram_q)
    );

    // divider operand selection, dividend left aligned
    always_comb begin
        case (i_cmd.div_sel)
            DS_FIRST: begin
                w_dvd  = {r_c1, (DIV_DW-SHORT_W)'(0)};
                w_dvs  = DIV_VW'(w_cols);
                w_dlen = DIV_LEN_SHORT;
            end
            DS_SECOND: begin
                w_dvd  = {r_c2, (DIV_DW-SHORT_W)'(0)};
                w_dvs  = DIV_VW'(w_cols);
                w_dlen = DIV_LEN_SHORT;
            end
            DS_ARITH: begin
                w_dvd  = {MID_W'(w_a_mag), (DIV_DW-MID_W)'(0)};
                w_dvs  = w_b_mag;
                w_dlen = DIV_LEN_MID;
            end
            DS_MEAN: begin
                w_dvd  = {w_sum_mag, (DIV_DW-MID_W)'(0)};
                w_dvs  = DIV_VW'(r_n);
                w_dlen = DIV_LEN_MID;
            end
            default: begin
                w_dvd  = r_acc;
                w_dvs  = DIV_VW'(r_n);
                w_dlen = DIV_LEN_LONG;
            end
        endcase
    end

    cfre_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dvd),
        .i_divisor  (w_dvs),
        .i_len      (w_dlen),
        .o_busy     (w_div_busy),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    cfre_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.sqrt_start),
        .i_x     (r_var),
        .o_busy  (w_sqrt_busy),
        .o_root  (w_root)
    );

    // sign fix of the quotient magnitude
    assign w_q32  = w_quot[VAL_W-1:0];
    assign w_qneg = (r_dsel == DS_MEAN) ? r_sum[SUM_W-1] : (r_a[VAL_W-1] ^ r_b[VAL_W-1]);
    assign w_qfix = w_qneg ? (VAL_W'(0) - w_q32) : w_q32;

    always_comb begin
        case (r_op)
            OP_ADD:  w_alu = r_a + r_b;
            OP_SUB:  w_alu = r_a - r_b;
            OP_MUL:  w_alu = VAL_W'(r_a * r_b);
            default: w_alu = '0;
        endcase
    end

    always_comb begin
        case (i_cmd.res_src)
            RES_CONST: w_res_sel = r_k;
            RES_ALU:   w_res_sel = w_alu;
            RES_MIN:   w_res_sel = r_mn;
            RES_MAX:   w_res_sel = r_mx;
            RES_SUM:   w_res_sel = r_sum[VAL_W-1:0];
            RES_ROOT:  w_res_sel = w_root[SQ_OW-1] ? {1'b0, {(VAL_W-1){1'b1}}} : w_root;
            default:   w_res_sel = '0;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
            r_clr_addr  <= '0;
        end else begin
            r_v1 <= i_cmd.walk_step;
            r_v2 <= r_v1 && i_cmd.pass2;
            r_v3 <= r_v2;
            if (i_cmd.clr_step) begin
                r_clr_addr <= r_clr_addr + CELL_AW'(1);
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_formula_kind;
            r_op   <= i_arith_op;
            r_c1   <= i_first_cell;
            r_c2   <= i_second_cell;
            r_k    <= i_constant_value;
            r_tgt  <= i_target_cell;
            r_stat <= STAT_OK;
        end
        if (i_cmd.lat_a) begin
            r_a <= r_c1[CELL_W-1] ? r_k : w_ram_q;
        end
        if (i_cmd.lat_b) begin
            r_b <= r_c2[CELL_W-1] ? r_k : w_ram_q;
        end
        if (i_cmd.div_start) begin
            r_dsel <= i_cmd.div_sel;
        end
        if (i_cmd.div_take) begin
            case (r_dsel)
                DS_FIRST: begin
                    r_fr <= w_quot[COLS_W-1:0];
                    r_fc <= w_rem[COLS_W-1:0];
                end
                DS_SECOND: begin
                    r_tr <= w_quot[COLS_W-1:0];
                    r_tc <= w_rem[COLS_W-1:0];
                end
                DS_ARITH: begin
                    r_res <= w_qfix;
                end
                DS_MEAN: begin
                    r_mean <= w_qfix;
                    r_res  <= w_qfix;
                end
                default: begin
                    // saturate the variance to 64 bits
                    r_var <= (|w_quot[DIV_DW-1:SQ_IW]) ? '1 : w_quot[SQ_IW-1:0];
                end
            endcase
        end
        if (i_cmd.res_load) begin
            r_res <= w_res_sel;
        end
        if (i_cmd.err_load) begin
            r_res  <= '0;
            r_stat <= i_cmd.err_code;
        end

        // range walk: step along the row, then jump to the next row start
        if (i_cmd.walk_init) begin
            r_addr <= r_c1[CELL_AW-1:0];
            r_row  <= r_c1[CELL_AW-1:0];
            r_ci   <= '0;
            r_ri   <= '0;
            if (i_cmd.pass2) begin
                r_acc <= '0;
            end else begin
                r_n   <= '0;
                r_sum <= '0;
            end
        end else if (i_cmd.walk_step) begin
            if (r_ci == w_wlen) begin
                r_ci   <= '0;
                r_ri   <= r_ri + COLS_W'(1);
                r_row  <= r_row + CELL_AW'(w_cols);
                r_addr <= r_row + CELL_AW'(w_cols);
            end else begin
                r_ci   <= r_ci + COLS_W'(1);
                r_addr <= r_addr + CELL_AW'(1);
            end
        end

        if (r_v1 && !i_cmd.pass2) begin
            if (r_n == '0 || w_v < r_mn) begin
                r_mn <= w_v;
            end
            if (r_n == '0 || w_v > r_mx) begin
                r_mx <= w_v;
            end
            r_n   <= r_n + N_W'(1);
            r_sum <= r_sum + SUM_W'(w_v);
        end
        if (r_v1) begin
            r_d <= w_dmag;
        end
        if (r_v2) begin
            r_sq <= r_d * r_d;
        end
        if (r_v3) begin
            r_acc <= r_acc + ACC_W'(r_sq);
        end

        if (i_cmd.finish) begin
            r_out_val  <= r_res;
            r_out_stat <= r_stat;
        end
    end

    assign o_sts.kind      = r_kind;
    assign o_sts.op        = r_op;
    assign o_sts.neg1      = r_c1[CELL_W-1];
    assign o_sts.neg2      = r_c2[CELL_W-1];
    assign o_sts.b_zero    = (r_b == '0);
    assign o_sts.inverted  = (r_tr < r_fr) || (r_tc < r_fc);
    assign o_sts.walk_last = (r_ci == w_wlen) && (r_ri == w_hlen);
    assign o_sts.pipe_busy = r_v1 || r_v2 || r_v3;
    assign o_sts.div_busy  = w_div_busy;
    assign o_sts.sqrt_busy = w_sqrt_busy;
    assign o_sts.clr_last  = &r_clr_addr;
    assign o_sts.out_free  = !r_out_valid || !i_out_stall;

    assign o_out_valid    = r_out_valid;
    assign o_result_value = r_out_val;
    assign o_status       = r_out_stat;

endmodule

FILE: rtl/cell_formula_range_evaluator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cell formula range evaluator
// Evaluates one spreadsheet formula per input item against a 1024-cell store
// and writes an error-free answer back into the target cell.
//
// Usage:
//   Input channel i_in_valid / o_in_stall carries one formula; output channel
//   o_out_valid / i_out_stall returns one result_value and status for it.
//   The column count is set over the APB port at address 0 while idle.
// Steps per item, from transfer in to result ready:
//   a constant is loaded directly; arithmetic reads both operands and, for a
//   divide, runs the divider; a range splits both corners with the divider,
//   checks them, then walks the rectangle at one cell per cycle; AVG adds
//   the division for the mean, STDEV adds the mean, a second pass over the
//   rectangle, the variance division and the square root. One cell-store read
//   port sets the walk rate, the shared one-bit-per-cycle divider sets the rest.
// Items are taken one at a time; the next one is taken while a result still
//   waits in the output register. A stalled result holds its value.
// After reset the whole store is cleared to zero, one cell after another, and
//   o_in_stall stays high until the clearing is done.
// ----------------------------------------------------------------------------
module cell_formula_range_evaluator
    import cfre_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [KIND_W-1:0] i_formula_kind,
    input  logic [OP_W-1:0]   i_arith_op,
    input  logic [CELL_W-1:0] i_first_cell,
    input  logic [CELL_W-1:0] i_second_cell,
    input  logic [VAL_W-1:0]  i_constant_value,
    input  logic [TGT_W-1:0]  i_target_cell,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [VAL_W-1:0]  o_result_value,
    output logic [STAT_W-1:0] o_status
);

    logic [COLS_W-1:0] r_cols;
    logic              w_cols_sel;
    logic              w_ready;
    t_cmd              w_cmd;
    t_sts              w_sts;

    assign w_cols_sel = ({paddr[APB_AW-1:2], 2'b00} == REG_COLS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= COLS_RESET;
        end else if (psel && penable && pwrite && w_cols_sel) begin
            r_cols <= pwdata[COLS_W-1:0];
        end
    end

    assign prdata = w_cols_sel ? APB_DW'(r_cols) : '0;
    assign pready = 1'b1;

    cfre_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_in_ready (w_ready)
    );

    cfre_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_cols           (r_cols),
        .i_formula_kind   (i_formula_kind),
        .i_arith_op       (i_arith_op),
        .i_first_cell     (i_first_cell),
        .i_second_cell    (i_second_cell),
        .i_constant_value (i_constant_value),
        .i_target_cell    (i_target_cell),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_result_value   (o_result_value),
        .o_status         (o_status)
    );

    assign o_in_stall = !w_ready;

endmodule

FILE: rtl/cfre_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cell formula range evaluator port checker
// Watches the top-level ports for handshake and result rules.
// ----------------------------------------------------------------------------
module cfre_checker
    import cfre_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [VAL_W-1:0]  o_result_value,
    input logic [STAT_W-1:0] o_status
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its value
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_result_value) && $stable(o_status))
        else $error("result changed while stalled");

    // an error result carries a zero value
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != STAT_OK) |-> o_result_value == '0)
        else $error("error result with nonzero value");

    // one item at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second transfer taken while busy");

    // the store clearing pass follows reset
    a_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("input taken during clearing pass");

endmodule

bind cell_formula_range_evaluator cfre_checker u_chk (.*);

FILE: verif/cell_formula_range_evaluator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cell formula range evaluator testbench
// Sends directed and random formulas over several column counts, predicts
// each result and status against a local copy of the cell store, and checks
// every output transfer in order under random input gaps and output stalls.
// ----------------------------------------------------------------------------
module cell_formula_range_evaluator_tb;
    import cfre_pkg::*;

    localparam logic [KIND_W-1:0] KIND_BAD = 3'd7;
    localparam logic [OP_W-1:0]   OP_BAD   = 3'd4;
    localparam int                MAX_CYCLES = 5000000;
    localparam logic [VAL_W-1:0]  INT_MIN = 32'h8000_0000;
    localparam logic [VAL_W-1:0]  INT_MAX = 32'h7FFF_FFFF;

    typedef struct {
        logic [VAL_W-1:0]  value;
        logic [STAT_W-1:0] status;
    } t_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    logic [KIND_W-1:0] i_formula_kind = '0;
    logic [OP_W-1:0]   i_arith_op = '0;
    logic [CELL_W-1:0] i_first_cell = '0;
    logic [CELL_W-1:0] i_second_cell = '0;
    logic [VAL_W-1:0]  i_constant_value = '0;
    logic [TGT_W-1:0]  i_target_cell = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [VAL_W-1:0]  o_result_value;
    logic [STAT_W-1:0] o_status;

    cell_formula_range_evaluator DUT (.*);

    always #5 i_clk = ~i_clk;

    // Predictor state
    logic [VAL_W-1:0]  sheet [CELL_COUNT];
    logic [COLS_W-1:0] col_setting = COLS_RESET;
    t_result           pending_results [$];
    int                mismatches = 0;
    int                cycle_count = 0;
    bit                quiet = 1'b0;
    int                stall_left = 0;

    function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
        logic [63:0] root;
        logic [63:0] bitv;
        root = '0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (x >= root + bitv) begin
                x = x - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic t_result eval_formula(input logic [KIND_W-1:0] kind,
                                             input logic [OP_W-1:0] op,
                                             input logic [CELL_W-1:0] c1,
                                             input logic [CELL_W-1:0] c2,
                                             input logic [VAL_W-1:0] k,
                                             input logic [TGT_W-1:0] tgt);
        t_result res;
        longint a, b, v, sum, mean, mn, mx;
        int unsigned cols, fr, fc, tr, tc, n;
        logic [127:0] acc, quot;
        logic [63:0] dev, var64, root;
        res.value = '0;
        res.status = STAT_OK;
        if (kind == KIND_CONST) begin
            res.value = k;
        end else if (kind == KIND_ARITH) begin
            a = c1[CELL_W-1] ? longint'($signed(k)) : longint'($signed(sheet[c1[9:0]]));
            b = c2[CELL_W-1] ? longint'($signed(k)) : longint'($signed(sheet[c2[9:0]]));
            case (op)
                OP_ADD: res.value = VAL_W'(a + b);
                OP_SUB: res.value = VAL_W'(a - b);
                OP_MUL: res.value = VAL_W'(a * b);
                OP_DIV: begin
                    if (b == 0) res.status = STAT_DIV_ZERO;
                    else res.value = VAL_W'(a / b);
                end
                default: res.status = STAT_UNSUPP;
            endcase
        end else if (kind == KIND_BAD) begin
            res.status = STAT_UNSUPP;
        end else if (c1[CELL_W-1] || c2[CELL_W-1]) begin
            res.status = STAT_INVERTED;
        end else begin
            cols = (col_setting == 0) ? 1 : col_setting;
            fr = c1 / cols; fc = c1 % cols;
            tr = c2 / cols; tc = c2 % cols;
            if (tr < fr || tc < fc) begin
                res.status = STAT_INVERTED;
            end else begin
                n = (tr - fr + 1) * (tc - fc + 1);
                sum = 0;
                mn = 0;
                mx = 0;
                for (int unsigned i = fr; i <= tr; i++)
                    for (int unsigned j = fc; j <= tc; j++) begin
                        v = $signed(sheet[(i * cols + j) % CELL_COUNT]);
                        if ((i == fr && j == fc) || v < mn) mn = v;
                        if ((i == fr && j == fc) || v > mx) mx = v;
                        sum += v;
                    end
                mean = sum / longint'(n);
                case (kind)
                    KIND_MIN: res.value = VAL_W'(mn);
                    KIND_MAX: res.value = VAL_W'(mx);
                    KIND_AVG: res.value = VAL_W'(mean);
                    KIND_SUM: res.value = VAL_W'(sum);
                    default: begin
                        acc = '0;
                        for (int unsigned i = fr; i <= tr; i++)
                            for (int unsigned j = fc; j <= tc; j++) begin
                                v = $signed(sheet[(i * cols + j) % CELL_COUNT]);
                                dev = (v >= mean) ? 64'(v - mean) : 64'(mean - v);
                                acc += 128'(dev) * 128'(dev);
                            end
                        quot = acc / 128'(n);
                        var64 = (quot[127:64] != 0) ? '1 : quot[63:0];
                        root = floor_sqrt(var64);
                        // saturate a deviation beyond the positive range
                        res.value = (root > 64'(INT_MAX)) ? INT_MAX : root[31:0];
                    end
                endcase
            end
        end
        if (res.status == STAT_OK) sheet[tgt] = res.value;
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_formula(input logic [KIND_W-1:0] kind, input logic [OP_W-1:0] op,
                                input logic [CELL_W-1:0] c1, input logic [CELL_W-1:0] c2,
                                input logic [VAL_W-1:0] k, input logic [TGT_W-1:0] tgt);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_formula_kind   <= kind;
        i_arith_op       <= op;
        i_first_cell     <= c1;
        i_second_cell    <= c2;
        i_constant_value <= k;
        i_target_cell    <= tgt;
        do @(posedge i_clk); while (o_in_stall);
        pending_results.push_back(eval_formula(kind, op, c1, c2, k, tgt));
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_columns(input logic [COLS_W-1:0] cols);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= REG_COLS;
        pwdata  <= APB_DW'(cols);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        col_setting = cols;
    endtask

    function automatic logic [VAL_W-1:0] pick_constant();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: return INT_MIN;
            1: return INT_MAX;
            2: return '0;
            3: return '1;
            4, 5, 6: return VAL_W'($urandom_range(0, 200)) - 32'd100;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [CELL_W-1:0] pick_cell();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12) return {1'b1, 10'($urandom)};
        if (r < 75) return CELL_W'($urandom_range(0, 127));
        return CELL_W'($urandom_range(0, 1023));
    endfunction

    task automatic send_random_formula();
        int r, cols, span;
        logic [KIND_W-1:0] kind;
        logic [OP_W-1:0] op;
        logic [CELL_W-1:0] c1, c2;
        logic [TGT_W-1:0] tgt;
        r = $urandom_range(0, 99);
        cols = (col_setting == 0) ? 1 : col_setting;
        op = OP_OP_pick(r);
        tgt = ($urandom_range(0, 3) != 0) ? TGT_W'($urandom_range(0, 127)) : TGT_W'($urandom);
        c1 = pick_cell();
        c2 = pick_cell();
        if (r < 25) begin
            kind = KIND_CONST;
        end else if (r < 50) begin
            kind = KIND_ARITH;
        end else if (r < 92) begin
            kind = KIND_W'($urandom_range(2, 6));
            if ($urandom_range(0, 9) != 0) begin
                // well-formed rectangle of a few rows and columns
                c1 = CELL_W'($urandom_range(0, 127));
                span = int'(c1) + $urandom_range(0, 3) * cols + $urandom_range(0, 3);
                if ($urandom_range(0, 49) == 0) span = $urandom_range(int'(c1), 1023);
                c2 = (span > 1023) ? c1 : CELL_W'(span);
            end
        end else begin
            kind = ($urandom_range(0, 1) != 0) ? KIND_BAD : KIND_ARITH;
            if (kind == KIND_ARITH) op = OP_W'($urandom_range(4, 7));
        end
        send_formula(kind, op, c1, c2, pick_constant(), tgt);
    endtask

    function automatic logic [OP_W-1:0] OP_OP_pick(input int r);
        if ($urandom_range(0, 19) == 0) return OP_W'($urandom_range(0, 7));
        return OP_W'($urandom_range(0, 3));
    endfunction

    task automatic run_random_phase(input logic [COLS_W-1:0] cols, input int items);
        write_columns(cols);
        repeat (items) send_random_formula();
        wait_drained();
    endtask

    task automatic test_constants_and_arith();
        send_formula(KIND_CONST, OP_ADD, '1, '1, INT_MIN, 10'd0);
        send_formula(KIND_CONST, OP_ADD, '1, '1, INT_MAX, 10'd1);
        send_formula(KIND_CONST, OP_ADD, '1, '1, 32'd0, 10'd2);
        send_formula(KIND_CONST, OP_ADD, '1, '1, '1, 10'd1023);
        send_formula(KIND_ARITH, OP_ADD, 11'd0, 11'd1, '0, 10'd3);
        send_formula(KIND_ARITH, OP_SUB, 11'd0, 11'd1, '0, 10'd4);
        send_formula(KIND_ARITH, OP_MUL, 11'd1, '1, 32'd3, 10'd5);
        send_formula(KIND_ARITH, OP_DIV, 11'd0, 11'd1023, '0, 10'd6);
        send_formula(KIND_ARITH, OP_DIV, 11'd0, 11'd2, '0, 10'd7);
        send_formula(KIND_ARITH, OP_DIV, '1, '1, 32'd7, 10'd8);
        send_formula(KIND_ARITH, OP_DIV, '1, 11'd5, -32'd7, 10'd9);
        send_formula(KIND_ARITH, OP_BAD, 11'd0, 11'd1, '0, 10'd10);
        send_formula(KIND_ARITH, 3'd7, 11'd0, 11'd1, '0, 10'd10);
        send_formula(KIND_BAD, OP_ADD, 11'd0, 11'd1, '0, 10'd10);
        wait_drained();
    endtask

    task automatic test_ranges();
        send_formula(KIND_CONST, OP_ADD, '1, '1, INT_MAX, 10'd32);
        send_formula(KIND_CONST, OP_ADD, '1, '1, INT_MAX, 10'd33);
        send_formula(KIND_MIN, OP_ADD, 11'd0, 11'd33, '0, 10'd40);
        send_formula(KIND_MAX, OP_ADD, 11'd0, 11'd33, '0, 10'd41);
        send_formula(KIND_SUM, OP_ADD, 11'd0, 11'd33, '0, 10'd42);
        send_formula(KIND_AVG, OP_ADD, 11'd0, 11'd33, '0, 10'd43);
        send_formula(KIND_STDEV, OP_ADD, 11'd0, 11'd33, '0, 10'd44);
        send_formula(KIND_STDEV, OP_ADD, 11'd0, 11'd1023, '0, 10'd45);
        send_formula(KIND_SUM, OP_ADD, '1, 11'd3, '0, 10'd46);
        send_formula(KIND_MIN, OP_ADD, 11'd3, 11'h7FF, '0, 10'd46);
        send_formula(KIND_MAX, OP_ADD, 11'd33, 11'd0, '0, 10'd46);
        send_formula(KIND_AVG, OP_ADD, 11'd1, 11'd32, '0, 10'd46);
        wait_drained();
    endtask

    // Output side: result checks and random stall bursts, mostly short
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLES) begin
            $display("TEST FAILED");
            $finish;
        end
        if (o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h status %0d", o_result_value, o_status);
            end else begin
                if (o_result_value !== pending_results[0].value ||
                    o_status !== pending_results[0].status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h/%0d got %h/%0d",
                                 pending_results[0].value, pending_results[0].status,
                                 o_result_value, o_status);
                end
                void'(pending_results.pop_front());
            end
        end
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (!quiet && $urandom_range(0, 9) < 2) begin
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                       : $urandom_range(0, 2);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    initial begin
        for (int i = 0; i < CELL_COUNT; i++) sheet[i] = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_columns(11'd32);
        test_constants_and_arith();
        test_ranges();
        run_random_phase(11'd32, 60);
        run_random_phase(11'd1, 40);
        quiet = 1'b1;
        run_random_phase(11'd1024, 40);
        quiet = 1'b0;
        run_random_phase(11'd0, 40);
        run_random_phase(11'd7, 50);
        run_random_phase(11'd13, 50);
        repeat (50) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
